// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the RMS/peak onset trigger checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define RPOT_ASSERT(lbl, ck, rst_n, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) prop) else $error(msg);

// Expression must never be true at a clock edge outside reset.
`define RPOT_NEVER(lbl, ck, rst_n, expr, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ----- src/rpot_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpot_pkg
// Fixed widths, register indexes and reset values of the onset trigger.
// ----------------------------------------------------------------------------
package rpot_pkg;

	// register field widths
	localparam int SET_W   = 7;
	localparam int THR_W   = 16;
	localparam int HOLD_W  = 20;
	localparam int CFG_W   = 20;
	localparam int CFG_IDX_W = 2;

	// window length = setting + base, setting saturated
	localparam logic [SET_W-1:0] WINDOW_BASE    = 7'd10;
	localparam logic [SET_W-1:0] WINDOW_SET_MAX = 7'd99;

	localparam logic [THR_W-1:0] THR_RESET = 16'h8000;

	// multiplier A operand carries threshold squared (32 bits)
	localparam int MUL_A_W = 32;
	// threshold^2 * window fits in 39 bits
	localparam int LIM_W   = 39;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MODE      = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF   = 2'd3;

	// trigger modes
	localparam logic MODE_RMS  = 1'b0;
	localparam logic MODE_PEAK = 1'b1;

endpackage

// ----- src/rms_peak_onset_trigger.sv -----
`timescale 1ns / 1ps
// result_valid is registered on leaving ST_DONE, after ST_WR, ST_ADD and, as the item needs,
//   ST_SUB, ST_LIM1 and ST_LIM2; a stalled result holds the next item in ST_DONE.
// One item at a time (item_ready only in ST_IDLE), over one shared multiplier.
// A window change without restart rebuilds the energy: FRD, FSQ, ADD states per older sample.
// Reset (arst_n low, async): empty history, zero energy/holdoff, registers to defaults.
// ----------------------------------------------------------------------------
// rms_peak_onset_trigger
// Sliding sum-of-squares / peak onset detector with holdoff, sequenced over
// one shared multiplier and a one-write one-read history memory.
// ----------------------------------------------------------------------------
module rms_peak_onset_trigger #(
	parameter int HISTORY_DEPTH = 128,
	parameter int SAMPLE_BITS   = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// configuration write port
	input  logic                                  cfg_we,
	input  logic [rpot_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [rpot_pkg::CFG_W-1:0]            cfg_data,
	// input item channel
	input  logic                                  item_valid,
	output logic                                  item_ready,
	input  logic signed [SAMPLE_BITS-1:0]         sample,
	input  logic                                  restart,
	// result channel
	output logic                                  result_valid,
	input  logic                                  result_ready,
	output logic                                  trigger,
	output logic                                  holding,
	output logic [2*SAMPLE_BITS+4:0]              window_energy
);

	// ------------------------------------------------------------------------
	// Derived widths
	//   IW  : history address
	//   FW  : fill count, holds HISTORY_DEPTH itself
	//   NW  : window length / element counter
	//   EW  : energy, up to 109 full-scale squares
	//   MBW : multiplier B operand (sample magnitude or threshold)
	//   PW  : product register, covers a square and threshold^2 * window
	// ------------------------------------------------------------------------
	localparam int IW  = $clog2(HISTORY_DEPTH);
	localparam int FW  = $clog2(HISTORY_DEPTH + 1);
	localparam int NW  = (FW > rpot_pkg::SET_W) ? FW : rpot_pkg::SET_W;
	localparam int EW  = 2 * SAMPLE_BITS + 5;
	localparam int MAW = rpot_pkg::MUL_A_W;
	localparam int MBW = (SAMPLE_BITS > rpot_pkg::THR_W) ? SAMPLE_BITS : rpot_pkg::THR_W;
	localparam int PW  = (2 * SAMPLE_BITS > rpot_pkg::LIM_W) ? 2 * SAMPLE_BITS
		: rpot_pkg::LIM_W;
	localparam int CW  = (EW > PW) ? EW : PW;

	typedef enum logic [3:0] {
		ST_IDLE,   // waiting for an input transfer
		ST_WR,     // write sample, read evicted entry, square the new sample
		ST_ADD,    // add a square to the energy
		ST_SUB,    // remove the evicted square
		ST_FRD,    // rebuild: read next older entry
		ST_FSQ,    // rebuild: square it
		ST_LIM1,   // threshold^2
		ST_LIM2,   // threshold^2 * window
		ST_DONE    // decide, load result register
	} state_t;

	// ------------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------------
	logic [rpot_pkg::SET_W-1:0]  window_setting_q;
	logic [rpot_pkg::THR_W-1:0]  threshold_q;
	logic                        trigger_mode_q;
	logic [rpot_pkg::HOLD_W-1:0] holdoff_len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_setting_q <= '0;
			threshold_q      <= rpot_pkg::THR_RESET;
			trigger_mode_q   <= rpot_pkg::MODE_RMS;
			holdoff_len_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rpot_pkg::REG_WINDOW: begin
					window_setting_q <= cfg_data[rpot_pkg::SET_W-1:0];
				end
				rpot_pkg::REG_THRESHOLD: begin
					threshold_q <= cfg_data[rpot_pkg::THR_W-1:0];
				end
				rpot_pkg::REG_MODE: begin
					trigger_mode_q <= cfg_data[0];
				end
				rpot_pkg::REG_HOLDOFF: begin
					holdoff_len_q <= cfg_data[rpot_pkg::HOLD_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// ------------------------------------------------------------------------
	// Effective window length: 0 when disabled, else min(sat(set)+10, depth)
	// ------------------------------------------------------------------------
	logic [rpot_pkg::SET_W-1:0] set_sat;
	logic [NW-1:0]              w_sum;
	logic [NW-1:0]              w_cur;

	always_comb begin
		set_sat = (window_setting_q > rpot_pkg::WINDOW_SET_MAX) ? rpot_pkg::WINDOW_SET_MAX
			: window_setting_q;
		w_sum   = NW'(set_sat) + NW'(rpot_pkg::WINDOW_BASE);
		if (window_setting_q == '0) begin
			w_cur = '0;
		end else if (w_sum > NW'(HISTORY_DEPTH)) begin
			w_cur = NW'(HISTORY_DEPTH);
		end else begin
			w_cur = w_sum;
		end
	end

	// ------------------------------------------------------------------------
	// Sequencer state and datapath registers
	// ------------------------------------------------------------------------
	state_t                      state_q;
	logic signed [SAMPLE_BITS-1:0] s_q;        // current sample
	logic [IW-1:0]               wp_q;         // next write slot
	logic [IW-1:0]               rp_q;         // rebuild read pointer
	logic [FW-1:0]               fill_q;       // samples since restart, saturating
	logic [EW-1:0]               energy_q;     // running sum of squares
	logic [NW-1:0]               w_q;          // window of this item
	logic [NW-1:0]               w_used_q;     // window that energy_q was built for
	logic [NW-1:0]               k_q;          // rebuild element count
	logic                        full_q;       // this item rebuilds the energy
	logic                        drop_q;       // this item evicts the oldest square
	logic [rpot_pkg::HOLD_W-1:0] hold_q;       // holdoff countdown
	logic [PW-1:0]               prod_q;       // shared multiplier output
	logic                        result_valid_q;
	logic                        trigger_q;
	logic                        holding_q;
	logic [EW-1:0]               energy_out_q;

	// history memory, one write and one registered read per cycle
	logic signed [SAMPLE_BITS-1:0] hist_mem [HISTORY_DEPTH];
	logic signed [SAMPLE_BITS-1:0] rd_q;
	logic                          mem_we;
	logic                          mem_re;
	logic [IW-1:0]                 rd_addr;

	// ------------------------------------------------------------------------
	// Address arithmetic: evicted slot = wp - w (mod depth), rebuild walks back
	// ------------------------------------------------------------------------
	logic [NW:0]   ev_sum;
	logic [NW:0]   ev_wrap;
	logic [IW-1:0] rp_nxt;
	logic [IW-1:0] wp_nxt;

	always_comb begin
		ev_sum  = (NW+1)'(wp_q) + (NW+1)'(HISTORY_DEPTH) - (NW+1)'(w_q);
		ev_wrap = (ev_sum >= (NW+1)'(HISTORY_DEPTH)) ? ev_sum - (NW+1)'(HISTORY_DEPTH)
			: ev_sum;
		rp_nxt  = (rp_q == '0) ? IW'(HISTORY_DEPTH - 1) : rp_q - 1'b1;
		wp_nxt  = (wp_q == IW'(HISTORY_DEPTH - 1)) ? '0 : wp_q + 1'b1;
		mem_we  = (state_q == ST_WR);
		mem_re  = (state_q == ST_WR) || (state_q == ST_FRD);
		rd_addr = (state_q == ST_FRD) ? rp_nxt : IW'(ev_wrap);
	end

	always_ff @(posedge clk) begin
		if (mem_re) begin
			rd_q <= hist_mem[rd_addr];
		end
		if (mem_we) begin
			hist_mem[wp_q] <= s_q;
		end
	end

	// ------------------------------------------------------------------------
	// Shared multiplier: operands chosen by the sequencer, product registered
	// in every state but ST_DONE and consumed by the state that follows.
	// ------------------------------------------------------------------------
	logic [SAMPLE_BITS-1:0] mag_s;
	logic [SAMPLE_BITS-1:0] mag_rd;
	logic [MAW-1:0]         mul_a;
	logic [MBW-1:0]         mul_b;
	logic [MAW+MBW-1:0]     mul_p;

	always_comb begin
		// two's complement magnitude; the most negative code maps to 2^(N-1)
		mag_s  = s_q[SAMPLE_BITS-1] ? (~s_q + 1'b1) : s_q;
		mag_rd = rd_q[SAMPLE_BITS-1] ? (~rd_q + 1'b1) : rd_q;
		unique case (state_q)
			ST_WR: begin
				mul_a = MAW'(mag_s);
				mul_b = MBW'(mag_s);
			end
			ST_LIM1: begin
				mul_a = MAW'(threshold_q);
				mul_b = MBW'(threshold_q);
			end
			ST_LIM2: begin
				mul_a = prod_q[MAW-1:0];
				mul_b = MBW'(w_q);
			end
			default: begin
				mul_a = MAW'(mag_rd);
				mul_b = MBW'(mag_rd);
			end
		endcase
		mul_p = mul_a * mul_b;
	end

	// ------------------------------------------------------------------------
	// Per-item decisions
	// ------------------------------------------------------------------------
	logic [FW-1:0] fill_eff;
	logic          full_cur;
	logic          drop_cur;
	logic [NW-1:0] n_cur;
	logic          rms_tail;
	logic          fire;
	logic          out_free;

	always_comb begin
		fill_eff = restart ? '0 : fill_q;
		// a changed window invalidates the running sum; after a restart the
		// sum is empty and fits any window
		full_cur = !restart && (w_cur != '0) && (w_cur != w_used_q);
		drop_cur = !full_cur && (w_cur != '0) && (NW'(fill_eff) >= w_cur);
		n_cur    = (w_q < NW'(fill_q)) ? w_q : NW'(fill_q);
		rms_tail = (trigger_mode_q == rpot_pkg::MODE_RMS) && (w_q != '0);
		if (trigger_mode_q == rpot_pkg::MODE_PEAK) begin
			fire = MBW'(mag_s) > MBW'(threshold_q);
		end else begin
			fire = (w_q != '0) && (CW'(energy_q) > CW'(prod_q));
		end
		out_free = !result_valid_q || result_ready;
	end

	// ------------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			s_q            <= '0;
			wp_q           <= '0;
			rp_q           <= '0;
			fill_q         <= '0;
			energy_q       <= '0;
			w_q            <= '0;
			w_used_q       <= '0;
			k_q            <= '0;
			full_q         <= 1'b0;
			drop_q         <= 1'b0;
			hold_q         <= '0;
			prod_q         <= '0;
			result_valid_q <= 1'b0;
			trigger_q      <= 1'b0;
			holding_q      <= 1'b0;
			energy_out_q   <= '0;
		end else begin
			// the limit product stays put while a finished item waits to go out
			if (state_q != ST_DONE) begin
				prod_q <= mul_p[PW-1:0];
			end
			if ((state_q == ST_DONE) && out_free) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						s_q      <= sample;
						w_q      <= w_cur;
						w_used_q <= w_cur;
						full_q   <= full_cur;
						drop_q   <= drop_cur;
						k_q      <= NW'(1);
						if (restart) begin
							fill_q <= '0;
							hold_q <= '0;
						end
						if (restart || full_cur || (w_cur == '0)) begin
							energy_q <= '0;
						end
						state_q <= ST_WR;
					end
				end
				ST_WR: begin
					rp_q    <= wp_q;
					wp_q    <= wp_nxt;
					if (fill_q < FW'(HISTORY_DEPTH)) begin
						fill_q <= fill_q + 1'b1;
					end
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					if (w_q != '0) begin
						energy_q <= energy_q + EW'(prod_q);
					end
					if (full_q && (k_q < n_cur)) begin
						state_q <= ST_FRD;
					end else if (drop_q) begin
						state_q <= ST_SUB;
					end else if (rms_tail) begin
						state_q <= ST_LIM1;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_SUB: begin
					energy_q <= energy_q - EW'(prod_q);
					state_q  <= rms_tail ? ST_LIM1 : ST_DONE;
				end
				ST_FRD: begin
					rp_q    <= rp_nxt;
					k_q     <= k_q + 1'b1;
					state_q <= ST_FSQ;
				end
				ST_FSQ: begin
					state_q <= ST_ADD;
				end
				ST_LIM1: begin
					state_q <= ST_LIM2;
				end
				ST_LIM2: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						holding_q      <= (hold_q != '0);
						energy_out_q   <= energy_q;
						if (hold_q != '0) begin
							// suppressed: count down, no trigger
							trigger_q <= 1'b0;
							hold_q    <= hold_q - 1'b1;
						end else begin
							trigger_q <= fire;
							if (fire) begin
								hold_q <= holdoff_len_q;
							end
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign item_ready    = (state_q == ST_IDLE);
	assign result_valid  = result_valid_q;
	assign trigger       = trigger_q;
	assign holding       = holding_q;
	assign window_energy = energy_out_q;

endmodule

// ----- src/rpot_chk.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// rpot_chk
// Port-level checks of the onset trigger, bound to the top level.
// ----------------------------------------------------------------------------
module rpot_chk #(
	parameter int SAMPLE_BITS = 16
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         item_valid,
	input logic                         item_ready,
	input logic                         result_valid,
	input logic                         result_ready,
	input logic                         trigger,
	input logic                         holding,
	input logic [2*SAMPLE_BITS+4:0]     window_energy
);

	// one item in flight: busy right after a transfer
	`RPOT_ASSERT(a_busy_after_in, clk, arst_n, item_valid && item_ready |=> !item_ready, "accepted a second item while busy")

	// no result appears in the cycle after a transfer
	`RPOT_ASSERT(a_no_fast_result, clk, arst_n, item_valid && item_ready && !result_valid |=> !result_valid, "result appeared one cycle after transfer")

	// a sample inside a holdoff never fires
	`RPOT_NEVER(a_no_fire_in_hold, clk, arst_n, result_valid && trigger && holding, "trigger during holdoff")

	// stalled result holds
	`RPOT_ASSERT(a_result_hold, clk, arst_n, result_valid && !result_ready |=> result_valid && $stable({trigger, holding, window_energy}), "stalled result changed")

endmodule

bind rms_peak_onset_trigger rpot_chk #(
	.SAMPLE_BITS(SAMPLE_BITS)
) u_rpot_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_ready   (item_ready),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.trigger      (trigger),
	.holding      (holding),
	.window_energy(window_energy)
);
